// ===== hw/rtl/averaged_knob_to_midi_cc_assert.svh =====
// Assertion macros for the averaged knob to MIDI control change block.
// Used by the top level only; the including module provides clk and arst_n.
`ifndef AVERAGED_KNOB_TO_MIDI_CC_ASSERT_SVH
`define AVERAGED_KNOB_TO_MIDI_CC_ASSERT_SVH
`ifndef ASSERT_OFF
`define AKMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AKMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AKMC_ASSERT_NOW(lbl, ante, cons, msg)
`define AKMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/akmc_pkg.sv =====
// Shared types and constants of the averaged knob to MIDI control change block.
// No dependencies.
package akmc_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int VALUE_W     = 7;
	localparam int VALUE_SHIFT = 3;
	localparam int CHANNEL_W   = 4;
	localparam int CTRL_W      = 7;
	localparam int LAST_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;
	localparam int STEP_W      = 3;
	localparam int DIV_ALIGN   = VALUE_SHIFT + VALUE_W - 1;

	localparam logic [LAST_W-1:0]    NOTHING_SENT = 8'hFF;
	localparam logic [STEP_W-1:0]    LAST_STEP    = 3'(VALUE_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SHIFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROLLER_BASE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROLLER_SHIFT = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic rd;
		logic push;
	} ring_ctl_t;

endpackage

// ===== hw/rtl/akmc_ring.sv =====
// Sample ring memory with running sum, write position and fill count.
// Depends on akmc_pkg.
module akmc_ring #(
	parameter int WINDOW_MAX = 64,
	parameter int AW = $clog2(WINDOW_MAX),
	parameter int LW = $clog2(WINDOW_MAX + 1),
	parameter int SW = akmc_pkg::SAMPLE_W + LW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  akmc_pkg::ring_ctl_t           ctl,
	input  logic [akmc_pkg::SAMPLE_W-1:0] sample,
	input  logic [LW-1:0]                 len,
	output logic [SW-1:0]                 sum_next,
	output logic [LW-1:0]                 fill_next
);
	import akmc_pkg::*;

	logic [SAMPLE_W-1:0] ram [WINDOW_MAX];
	logic [SAMPLE_W-1:0] rd_q;
	logic [SW-1:0]       sum_q;
	logic [AW-1:0]       pos_q;
	logic [LW-1:0]       fill_q;
	logic [LW-1:0]       pos_inc;
	logic [AW-1:0]       pos_next;
	logic [SAMPLE_W-1:0] oldest;
	logic                full;

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q <= ram[pos_q];
		end
		if (ctl.push) begin
			ram[pos_q] <= sample;
		end
	end

	// Slots beyond the fill count have not been written since the last clear.
	assign full      = (fill_q == len);
	assign oldest    = full ? rd_q : '0;
	assign sum_next  = sum_q - SW'(oldest) + SW'(sample);
	assign fill_next = full ? fill_q : fill_q + LW'(1);
	assign pos_inc   = LW'(pos_q) + LW'(1);
	assign pos_next  = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			pos_q  <= '0;
			fill_q <= '0;
		end else if (ctl.clear) begin
			sum_q  <= '0;
			pos_q  <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			sum_q  <= sum_next;
			pos_q  <= pos_next;
			fill_q <= fill_next;
		end
	end

endmodule

// ===== hw/rtl/akmc_div.sv =====
// Bit-serial restoring divider giving the 7-bit control value sum / (8 * count).
// Depends on akmc_pkg.
module akmc_div #(
	parameter int LW = 7,
	parameter int SW = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SW-1:0]                dividend,
	input  logic [LW-1:0]                count,
	output logic                         done,
	output logic [akmc_pkg::VALUE_W-1:0] quotient
);
	import akmc_pkg::*;

	logic [SW-1:0]      rem_q;
	logic [SW-1:0]      dsr_q;
	logic [VALUE_W-1:0] quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic               fits;

	assign fits = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, most significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= SW'(count) << DIV_ALIGN;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[VALUE_W-2:0], fits};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/averaged_knob_to_midi_cc.sv =====
// Averaged knob to MIDI control change: top level with control sequencer and result register.
// Depends on akmc_pkg, akmc_ring, akmc_div and averaged_knob_to_midi_cc_assert.svh.
//
// Each item on the input channel (in_valid, in_ready, adc_sample) is one 10-bit knob
// reading. With a window length of two or more the reading enters the sample ring and
// the running sum is divided by the fill count; otherwise the raw reading is used. The
// level is scaled to seven bits and an item appears on the output channel (out_valid,
// out_ready, cc_value, cc_channel, cc_controller) only when the value changes.
// From acceptance an item passes the sum update (only when averaging), the bit-serial
// divider, a step in which the divider reports completion and the change compare before
// it reaches the result register. The input is ready again only after the item has left
// the compare step, so a new item is not accepted before the last one is through.
// The result register holds a result until it is taken; while it is full, a further
// changed value waits in the compare step and the input is not ready.
// Reset clears the configuration, the running sum, the fill count and the write
// position; stale ring entries are never used because the fill count masks them, so no
// clearing pass is needed. A write to the window length restarts averaging the same way.
module averaged_knob_to_midi_cc #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [akmc_pkg::SAMPLE_W-1:0]    adc_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [akmc_pkg::VALUE_W-1:0]     cc_value,
	output logic [akmc_pkg::CHANNEL_W-1:0]   cc_channel,
	output logic [akmc_pkg::CTRL_W-1:0]      cc_controller,
	input  logic                             cfg_we,
	input  logic [akmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [akmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import akmc_pkg::*;

	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int SW = SAMPLE_W + LW;

	state_t                state_q;
	state_t                state_d;
	logic [CFG_DATA_W-1:0] average_length_q;
	logic [CHANNEL_W-1:0]  midi_channel_q;
	logic [CHANNEL_W-1:0]  channel_shift_q;
	logic [CTRL_W-1:0]     controller_base_q;
	logic [CTRL_W-1:0]     controller_shift_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [LAST_W-1:0]     last_q;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    cc_value_q;
	logic [CHANNEL_W-1:0]  cc_channel_q;
	logic [CTRL_W-1:0]     cc_controller_q;

	logic [LW-1:0]         len;
	logic                  avg_on;
	ring_ctl_t             ring_ctl;
	logic [SW-1:0]         sum_next;
	logic [LW-1:0]         fill_next;
	logic                  div_start;
	logic [SW-1:0]         div_dividend;
	logic [LW-1:0]         div_count;
	logic                  div_done;
	logic [VALUE_W-1:0]    div_quotient;
	logic                  changed;
	logic                  slot_free;
	logic                  emit;

	assign len = (32'(average_length_q) > 32'(WINDOW_MAX)) ? LW'(WINDOW_MAX)
	                                                       : LW'(average_length_q);
	assign avg_on    = (len >= LW'(2));
	assign changed   = ({1'b0, div_quotient} != last_q);
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_length_q   <= '0;
			midi_channel_q     <= '0;
			channel_shift_q    <= '0;
			controller_base_q  <= '0;
			controller_shift_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AVERAGE_LENGTH:   average_length_q   <= cfg_data;
				REG_MIDI_CHANNEL:     midi_channel_q     <= cfg_data[CHANNEL_W-1:0];
				REG_CHANNEL_SHIFT:    channel_shift_q    <= cfg_data[CHANNEL_W-1:0];
				REG_CONTROLLER_BASE:  controller_base_q  <= cfg_data[CTRL_W-1:0];
				REG_CONTROLLER_SHIFT: controller_shift_q <= cfg_data[CTRL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = avg_on ? ST_UPD : ST_DIV;
				end
			end
			ST_UPD: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!changed || slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		ring_ctl.clear = cfg_we && (cfg_index == REG_AVERAGE_LENGTH);
		ring_ctl.rd    = 1'b0;
		ring_ctl.push  = 1'b0;
		div_start      = 1'b0;
		div_dividend   = SW'(adc_sample);
		div_count      = LW'(1);
		emit           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ring_ctl.rd = avg_on;
					div_start   = !avg_on;
				end
			end
			ST_UPD: begin
				ring_ctl.push = 1'b1;
				div_start     = 1'b1;
				div_dividend  = sum_next;
				div_count     = fill_next;
			end
			ST_DIV: ;
			ST_DONE: emit = changed && slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= NOTHING_SENT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				last_q      <= {1'b0, div_quotient};
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= adc_sample;
		end
		if (emit) begin
			cc_value_q      <= div_quotient;
			cc_channel_q    <= midi_channel_q + channel_shift_q;
			cc_controller_q <= controller_base_q + controller_shift_q;
		end
	end

	akmc_ring #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.sample    (sample_q),
		.len       (len),
		.sum_next  (sum_next),
		.fill_next (fill_next)
	);

	akmc_div #(
		.LW (LW),
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.count    (div_count),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign out_valid     = out_valid_q;
	assign cc_value      = cc_value_q;
	assign cc_channel    = cc_channel_q;
	assign cc_controller = cc_controller_q;

	`include "averaged_knob_to_midi_cc_assert.svh"

	`AKMC_ASSERT_NOW(a_done_in_div, div_done, state_q == ST_DIV, "divider finished outside the divide step")
	`AKMC_ASSERT_NOW(a_upd_after_idle, state_q == ST_UPD, $past(state_q) == ST_IDLE, "sum update without an accepted item")
	`AKMC_ASSERT_NEXT(a_emit_records, emit, out_valid && (last_q == {1'b0, cc_value}), "result register and last value disagree")

endmodule
